// ===== hdl/rpo_pkg.sv =====
// Package: mode codes, luma weights and channel constants for the RGB point operations.
`default_nettype none

package rpo_pkg;

	typedef logic [7:0] chan_t;
	typedef logic [2:0] mode_t;

	// Mode codes
	localparam mode_t MODE_INVERT  = 3'd0;
	localparam mode_t MODE_DARKEN  = 3'd1;
	localparam mode_t MODE_LIGHTEN = 3'd2;
	localparam mode_t MODE_MERGE   = 3'd3;
	localparam mode_t MODE_BW      = 3'd4;

	// Q16 luma weights; they sum to 65536, so the luma never exceeds 255
	localparam logic [15:0] LUMA_WR = 16'd19595;
	localparam logic [15:0] LUMA_WG = 16'd38470;
	localparam logic [15:0] LUMA_WB = 16'd7471;

	localparam int unsigned PROD_W = 24;

	localparam chan_t CH_MAX       = 8'd255;
	localparam chan_t CH_MIN       = 8'd0;
	localparam chan_t LIGHT_OFFSET = 8'd127;
	localparam chan_t BW_RESET     = 8'd128;

endpackage : rpo_pkg

`default_nettype wire

// ===== hdl/rpo_chan_op.sv =====
// Per-channel point operation: invert, darken, lighten, merge or pass.
`default_nettype none

module rpo_chan_op
	import rpo_pkg::*;
(
	input  wire mode_t mode,
	input  wire chan_t prim,
	input  wire chan_t second,
	output chan_t      result
);

	logic [8:0] sum;

	// Widen before adding so the merge mean keeps its carry
	assign sum = {1'b0, prim} + {1'b0, second};

	// Select the channel result; black-white is resolved later in the pipe
	always_comb begin
		case (mode)
			MODE_INVERT:  result = CH_MAX - prim;
			MODE_DARKEN:  result = {1'b0, prim[7:1]};
			MODE_LIGHTEN: result = {1'b0, prim[7:1]} + LIGHT_OFFSET;
			MODE_MERGE:   result = sum[8:1];
			default:      result = prim;
		endcase
	end

endmodule : rpo_chan_op

`default_nettype wire

// ===== hdl/rpo_luma.sv =====
// Two-stage Q16 luma: weighted products, then sum and truncate.
`default_nettype none

module rpo_luma
	import rpo_pkg::*;
(
	input  wire   clk,
	input  wire   chan_t red,
	input  wire   chan_t green,
	input  wire   chan_t blue,
	output chan_t luma
);

	logic [PROD_W-1:0] prod_r_s1;
	logic [PROD_W-1:0] prod_g_s1;
	logic [PROD_W-1:0] prod_b_s1;
	logic [PROD_W-1:0] sum;
	chan_t             luma_s2;

	// Register each weighted product; widen first so no product bit is lost
	always_ff @(posedge clk) begin
		prod_r_s1 <= {16'd0, red} * {8'd0, LUMA_WR};
		prod_g_s1 <= {16'd0, green} * {8'd0, LUMA_WG};
		prod_b_s1 <= {16'd0, blue} * {8'd0, LUMA_WB};
	end

	// Sum cannot exceed 255 * 65536, so 24 bits hold it
	assign sum = prod_r_s1 + prod_g_s1 + prod_b_s1;

	// Keep the integer part
	always_ff @(posedge clk) begin
		luma_s2 <= sum[PROD_W-1:16];
	end

	assign luma = luma_s2;

endmodule : rpo_luma

`default_nettype wire

// ===== hdl/rgb_pixel_point_ops.sv =====
// Top level: three-stage pixel pipeline with threshold register.
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  ------------------
//  input     mode, red, green, blue, *_second             start && !busy
//  result    red_out, green_out, blue_out                 done (one cycle)
//  config    cfg_data                                     cfg_we
//
// One word enters per clock; its result passes the s1, s2 and s3 registers and
// appears on done. The pipe depth is set by the luma path: multiply, sum, compare.
// busy stays low: the pipe never stalls and the receiver takes every result.
// arst_n clears the valid bits and loads the threshold with 128.
`default_nettype none

module rgb_pixel_point_ops
	import rpo_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	output logic  busy,
	input  wire   mode_t mode,
	input  wire   chan_t red,
	input  wire   chan_t green,
	input  wire   chan_t blue,
	input  wire   chan_t red_second,
	input  wire   chan_t green_second,
	input  wire   chan_t blue_second,
	input  wire   cfg_we,
	input  wire   chan_t cfg_data,
	output logic  done,
	output chan_t red_out,
	output chan_t green_out,
	output chan_t blue_out
);

	chan_t bw_threshold_q;

	logic  accept;
	chan_t red_op;
	chan_t green_op;
	chan_t blue_op;
	chan_t luma;

	logic  valid_s1, valid_s2, valid_s3;
	logic  is_bw_s1, is_bw_s2;
	chan_t red_s1, green_s1, blue_s1;
	chan_t red_s2, green_s2, blue_s2;
	chan_t red_s3, green_s3, blue_s3;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Hold the black-white threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_threshold_q <= BW_RESET;
		end else if (cfg_we) begin
			bw_threshold_q <= cfg_data;
		end
	end

	rpo_chan_op u_op_red (
		.mode   (mode),
		.prim   (red),
		.second (red_second),
		.result (red_op)
	);

	rpo_chan_op u_op_green (
		.mode   (mode),
		.prim   (green),
		.second (green_second),
		.result (green_op)
	);

	rpo_chan_op u_op_blue (
		.mode   (mode),
		.prim   (blue),
		.second (blue_second),
		.result (blue_op)
	);

	rpo_luma u_luma (
		.clk   (clk),
		.red   (red),
		.green (green),
		.blue  (blue),
		.luma  (luma)
	);

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Advance the channel results alongside the luma path
	always_ff @(posedge clk) begin
		is_bw_s1 <= (mode == MODE_BW);
		red_s1   <= red_op;
		green_s1 <= green_op;
		blue_s1  <= blue_op;
		is_bw_s2 <= is_bw_s1;
		red_s2   <= red_s1;
		green_s2 <= green_s1;
		blue_s2  <= blue_s1;
	end

	// Resolve black-white against the threshold
	always_ff @(posedge clk) begin
		if (is_bw_s2) begin
			red_s3   <= (luma >= bw_threshold_q) ? CH_MAX : CH_MIN;
			green_s3 <= (luma >= bw_threshold_q) ? CH_MAX : CH_MIN;
			blue_s3  <= (luma >= bw_threshold_q) ? CH_MAX : CH_MIN;
		end else begin
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
		end
	end

	assign done      = valid_s3;
	assign red_out   = red_s3;
	assign green_out = green_s3;
	assign blue_out  = blue_s3;

endmodule : rgb_pixel_point_ops

`default_nettype wire
